// ===== rtl/rng_pkg.sv =====
// Shared types and constants for the radius neighbor graph block.
// No dependencies; every rtl file refers to it by scoped names.
package rng_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_DIMS   = 8;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int MASK_W     = MAX_POINTS - 1;
   localparam int ROW_W      = MAX_DIMS * COORD_W;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int PAIRS      = (MAX_DIMS + 1) / 2;
   localparam int PAIR_W     = SQ_W + 1;
   localparam int SUM_W      = SQ_W + $clog2(MAX_DIMS);
   localparam int RADIUS_W   = 37;
   localparam int DIMS_W     = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int DIST_LAT   = 5;   // tag stages up to the sum register

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQUARED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE    = CSR_IDX_W'(1);

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(16777216);
   localparam logic [DIMS_W-1:0]   DIMS_RESET   = DIMS_W'(2);

   // one stored point read per issue
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [IDX_W-1:0] idx;
   } rng_issue_type;

   typedef struct packed {
      logic             vld;
      logic             last;
      logic [IDX_W-1:0] idx;
      logic             hit;
   } rng_hit_type;

endpackage

// ===== rtl/rng_store.sv =====
// Point store: one row holds all coordinates of one point.
// One write port, one read port with registered read data. Uses rng_pkg.
module rng_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [rng_pkg::IDX_W-1:0] wr_addr,
   input  logic [rng_pkg::ROW_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [rng_pkg::IDX_W-1:0] rd_addr,
   output logic [rng_pkg::ROW_W-1:0] rd_data
);

   logic [rng_pkg::ROW_W-1:0] mem [rng_pkg::MAX_POINTS];
   logic [rng_pkg::ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rng_dist.sv =====
// Squared distance pipeline: per-coordinate lanes for difference and square,
// a two-level registered adder tree, then the radius compare. Uses rng_pkg.
module rng_dist (
   input  logic                         clock,
   input  logic                         reset,
   input  rng_pkg::rng_issue_type       issue,
   input  logic [rng_pkg::ROW_W-1:0]    rd_row,
   input  logic [rng_pkg::ROW_W-1:0]    point,
   input  logic [rng_pkg::DIMS_W-1:0]   act_dims,
   input  logic [rng_pkg::RADIUS_W-1:0] radius,
   output rng_pkg::rng_hit_type         result
);

   rng_pkg::rng_issue_type tag_ff [rng_pkg::DIST_LAT];

   logic signed [rng_pkg::DIFF_W-1:0] diff_ff [rng_pkg::MAX_DIMS];
   logic        [rng_pkg::SQ_W-1:0]   sq_ff   [2*rng_pkg::PAIRS];
   logic        [rng_pkg::PAIR_W-1:0] pair_ff [rng_pkg::PAIRS];
   logic        [rng_pkg::SUM_W-1:0]  sum_ff;
   logic        [rng_pkg::SUM_W-1:0]  sum_in;
   rng_pkg::rng_hit_type              result_ff;

   // tag stage 0 lines up with the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < rng_pkg::DIST_LAT; s++) begin
            tag_ff[s] <= '0;
         end
         result_ff <= '0;
      end else begin
         tag_ff[0] <= issue;
         for (int s = 1; s < rng_pkg::DIST_LAT; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         result_ff.vld  <= tag_ff[rng_pkg::DIST_LAT-1].vld;
         result_ff.last <= tag_ff[rng_pkg::DIST_LAT-1].last;
         result_ff.idx  <= tag_ff[rng_pkg::DIST_LAT-1].idx;
         result_ff.hit  <= rng_pkg::RADIUS_W'(sum_ff) <= radius;
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < rng_pkg::MAX_DIMS; d++) begin
         if (rng_pkg::DIMS_W'(d) < act_dims) begin
            diff_ff[d] <= rng_pkg::DIFF_W'($signed(point[d*rng_pkg::COORD_W +: rng_pkg::COORD_W]))
                        - rng_pkg::DIFF_W'($signed(rd_row[d*rng_pkg::COORD_W +: rng_pkg::COORD_W]));
         end else begin
            diff_ff[d] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 2*rng_pkg::PAIRS; d++) begin
         if (d < rng_pkg::MAX_DIMS) begin
            sq_ff[d] <= rng_pkg::SQ_W'(diff_ff[d] * diff_ff[d]);
         end else begin
            sq_ff[d] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < rng_pkg::PAIRS; k++) begin
         pair_ff[k] <= rng_pkg::PAIR_W'(sq_ff[2*k]) + rng_pkg::PAIR_W'(sq_ff[2*k+1]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < rng_pkg::PAIRS; k++) begin
         sum_in = sum_in + rng_pkg::SUM_W'(pair_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign result = result_ff;

endmodule

// ===== rtl/radius_neighbor_graph_top.sv =====
// Radius neighbor graph top: handshakes, config registers, sequencer and
// result register. Depends on rng_pkg, rng_store and rng_dist.
//
//   channel  dir  handshake            word
//   req_     in   req_valid/req_stall  first_point, coord_0..coord_7
//   rsp_     out  rsp_valid/rsp_stall  point_number, neighbor_mask, capacity_overflow
//   csr_     in   csr_valid/csr_ready  csr_index, csr_wdata
//
// A point numbered n is compared with the n points stored before it: one stored
// point row read per cycle from the store, then through the distance pipeline.
// A point with n = 0 or an overflowed point skips the scan and goes straight to finish.
// req_stall is high while a point is in work; the result register lets the
// next word in while the previous result waits on rsp_stall.
// Reset (synchronous) empties the set and loads the register defaults.
module radius_neighbor_graph_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_first_point,
   input  logic signed [15:0]             req_coord_0,
   input  logic signed [15:0]             req_coord_1,
   input  logic signed [15:0]             req_coord_2,
   input  logic signed [15:0]             req_coord_3,
   input  logic signed [15:0]             req_coord_4,
   input  logic signed [15:0]             req_coord_5,
   input  logic signed [15:0]             req_coord_6,
   input  logic signed [15:0]             req_coord_7,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rng_pkg::IDX_W-1:0]      rsp_point_number,
   output logic [rng_pkg::MASK_W-1:0]     rsp_neighbor_mask,
   output logic                           rsp_capacity_overflow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rng_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rng_pkg::RADIUS_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [rng_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [rng_pkg::CNT_W-1:0]     n_ff, n_in;
   logic                          ovf_ff, ovf_in;
   logic [rng_pkg::ROW_W-1:0]     pt_ff, pt_in;
   logic [rng_pkg::IDX_W-1:0]     scan_ff, scan_in;
   logic [rng_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic [rng_pkg::RADIUS_W-1:0]  radius_ff, radius_in;
   logic [rng_pkg::DIMS_W-1:0]    dims_ff, dims_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rng_pkg::IDX_W-1:0]     rsp_num_ff, rsp_num_in;
   logic [rng_pkg::MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic [rng_pkg::ROW_W-1:0]     in_row;
   logic [rng_pkg::CNT_W-1:0]     n_new;
   logic                          full;
   logic                          accept;
   logic                          wr_en;
   logic [rng_pkg::ROW_W-1:0]     rd_row;
   logic [rng_pkg::DIMS_W-1:0]    act_dims;
   rng_pkg::rng_issue_type        issue;
   rng_pkg::rng_hit_type          hit;

   assign in_row = {req_coord_7, req_coord_6, req_coord_5, req_coord_4,
                    req_coord_3, req_coord_2, req_coord_1, req_coord_0};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign n_new     = req_first_point ? '0 : count_ff;
   assign full      = (n_new >= rng_pkg::CNT_W'(rng_pkg::MAX_POINTS));
   assign wr_en     = accept && !full;

   assign act_dims = (dims_ff == '0) ? rng_pkg::DIMS_W'(1) :
                     (dims_ff > rng_pkg::DIMS_W'(rng_pkg::MAX_DIMS)) ?
                        rng_pkg::DIMS_W'(rng_pkg::MAX_DIMS) : dims_ff;

   assign issue.vld  = (state_ff == ST_SCAN);
   assign issue.idx  = scan_ff;
   assign issue.last = (rng_pkg::CNT_W'(scan_ff) == n_ff - rng_pkg::CNT_W'(1));

   rng_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_new[rng_pkg::IDX_W-1:0]),
      .wr_data (in_row),
      .rd_en   (issue.vld),
      .rd_addr (scan_ff),
      .rd_data (rd_row)
   );

   rng_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .rd_row   (rd_row),
      .point    (pt_ff),
      .act_dims (act_dims),
      .radius   (radius_ff),
      .result   (hit)
   );

   // config writes
   assign csr_ready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      dims_in   = dims_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rng_pkg::CSR_RADIUS_SQUARED: radius_in = csr_wdata;
            rng_pkg::CSR_DIMS_IN_USE:    dims_in   = csr_wdata[rng_pkg::DIMS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      pt_in        = pt_ff;
      scan_in      = scan_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (hit.vld) begin
         mask_in = mask_ff | (rng_pkg::MASK_W'(hit.hit) << hit.idx);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in    = n_new;
               pt_in   = in_row;
               mask_in = '0;
               scan_in = '0;
               ovf_in  = full;
               if (full) begin
                  state_in = ST_FINISH;
               end else begin
                  count_in = n_new + rng_pkg::CNT_W'(1);
                  state_in = (n_new == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + rng_pkg::IDX_W'(1);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (hit.vld && hit.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = ovf_ff ? '0 : n_ff[rng_pkg::IDX_W-1:0];
               rsp_mask_in  = ovf_ff ? '0 : mask_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= rng_pkg::RADIUS_RESET;
         dims_ff      <= rng_pkg::DIMS_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         dims_ff      <= dims_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      ovf_ff      <= ovf_in;
      pt_ff       <= pt_in;
      scan_ff     <= scan_in;
      mask_ff     <= mask_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_point_number      = rsp_num_ff;
   assign rsp_neighbor_mask     = rsp_mask_ff;
   assign rsp_capacity_overflow = rsp_ovf_ff;

   // compare results only come back while a scan is in flight
   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      hit.vld |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside scan");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rng_pkg::CNT_W'(rng_pkg::MAX_POINTS))
      else $error("point count beyond capacity");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("finished result not loaded");

   a_mask_earlier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_neighbor_mask >> rsp_point_number) == '0))
      else $error("neighbor bit at or above own number");

   a_ovf_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_capacity_overflow) |->
         (rsp_point_number == '0 && rsp_neighbor_mask == '0))
      else $error("overflow word carries data");

endmodule
